[design/assert_macros.svh]
// Assertion macros used by the statistics core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, suspended while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/dbms_pkg.sv]
// Types and constants of the magnitude statistics block.
package dbms_pkg;

  localparam int ROW_W         = 6;
  localparam int RE_W          = 16;
  localparam int DB_W          = 18;
  localparam int STD_W         = 16;
  localparam int CNT_W         = 12;
  localparam int SUM_W         = 31;
  localparam int SSQ_W         = 48;
  localparam int DIV_W         = 31;
  localparam int MAX_PORTS_DEF = 64;

  localparam logic signed [DB_W-1:0] DB_FLOOR  = -18'sd102400;
  localparam logic signed [DB_W-1:0] DB_CEIL   = 18'sd1024;
  localparam logic [CNT_W-1:0]       COUNT_CAP = 12'd4095;
  localparam logic signed [18:0]     TEN_LOG10_2_Q16 = 19'sd197283;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_NORM,
    ST_LOG,
    ST_SCALE,
    ST_SQUARE,
    ST_ACC,
    ST_FIN_LO,
    ST_FIN_HI,
    ST_FIN_B,
    ST_FIN_A,
    ST_FIN_VAR,
    ST_DIV_MEAN,
    ST_SQRT,
    ST_DIV_STD,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[design/dbms_entry_if.sv]
// Channel carrying one matrix entry per transfer.
interface dbms_entry_if import dbms_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ROW_W-1:0]       row_index;
  logic [ROW_W-1:0]       col_index;
  logic signed [RE_W-1:0] real_part;
  logic signed [RE_W-1:0] imag_part;
  logic                   last_entry;

  modport source (output valid, row_index, col_index, real_part, imag_part, last_entry,
                  input ready);
  modport sink (input valid, row_index, col_index, real_part, imag_part, last_entry,
                output ready);
endinterface

[design/dbms_stats_if.sv]
// Channel carrying one statistics result per transfer.
interface dbms_stats_if import dbms_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [DB_W-1:0] max_db;
  logic [ROW_W-1:0]       max_row;
  logic [ROW_W-1:0]       max_col;
  logic signed [DB_W-1:0] min_db;
  logic signed [DB_W-1:0] mean_db;
  logic [STD_W-1:0]       std_db;
  logic [CNT_W-1:0]       pair_count;

  modport source (output valid, max_db, max_row, max_col, min_db, mean_db, std_db,
                  pair_count, input ready);
  modport sink (input valid, max_db, max_row, max_col, min_db, mean_db, std_db,
                pair_count, output ready);
endinterface

[design/dbms_div.sv]
// Restoring divider producing one quotient bit per cycle.
module dbms_div import dbms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int IT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [IT_W-1:0]  iter;
  logic [CNT_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] divisor;
  logic [CNT_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quo[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == IT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[design/db_magnitude_stream_statistics_core.sv]
// Channel  Dir  Handshake     Payload
// entry    in   valid/ready   row_index, col_index, real_part, imag_part, last_entry
// stats    out  valid/ready   max_db, max_row, max_col, min_db, mean_db, std_db, pair_count
//
// One entry at a time. A skipped entry that is not final leaves the core idle;
// an accumulated one passes the squaring states, the one-bit normalising shift
// (up to 31 shifts) and the 16 squarings of the log2 unit, both of which a zero
// magnitude skips. A final entry then runs the set-up states FIN_LO to FIN_VAR,
// two divider passes, 30 square-root steps and the write; an empty set goes
// straight to the write. Reset is synchronous and clears the accumulators; a
// stalled result holds in the output register while the next entries are taken.
`include "assert_macros.svh"

module db_magnitude_stream_statistics_core import dbms_pkg::*; #(
  parameter int MAX_PORTS = MAX_PORTS_DEF
) (
  input logic               clk,
  input logic               rst,
  dbms_entry_if.sink        entry,
  dbms_stats_if.source      stats
);

  localparam int IDX_W = 9;

  state_t state, state_next;

  logic [ROW_W-1:0]       row_r, col_r;
  logic signed [RE_W-1:0] re_r, im_r;
  logic                   last_r;

  logic [31:0]            m2;
  logic [31:0]            x;
  logic [4:0]             expo;
  logic [15:0]            frac;
  logic [3:0]             iter;
  logic signed [DB_W-1:0] v;
  logic [35:0]            vsq;

  logic signed [DB_W-1:0]  run_max, run_min;
  logic [ROW_W-1:0]        amax_row, amax_col;
  logic signed [SUM_W-1:0] run_sum;
  logic [SSQ_W-1:0]        run_ssq;
  logic [CNT_W-1:0]        total;

  logic                    sum_neg;
  logic [29:0]             sabs;
  logic [35:0]             plo, phi;
  logic [59:0]             bsq, asq, var_r;
  logic [59:0]             sq_res, sq_rem, sq_bit;
  logic signed [DB_W-1:0]  mean_r;
  logic [STD_W-1:0]        std_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                    take;
  logic                    slot_free;
  logic signed [31:0]      re_sq, im_sq;
  logic [63:0]             lsq;
  logic [32:0]             lsh;
  logic signed [22:0]      lval;
  logic signed [41:0]      prod;
  logic [59:0]             trial;
  logic                    sq_ge;
  logic [59:0]             res_n;
  logic [DB_W-1:0]         q_db;

  dbms_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign take = (entry.row_index != entry.col_index)
             && ({{(IDX_W-ROW_W){1'b0}}, entry.row_index} < IDX_W'(MAX_PORTS))
             && ({{(IDX_W-ROW_W){1'b0}}, entry.col_index} < IDX_W'(MAX_PORTS))
             && (total < COUNT_CAP);

  assign slot_free = !stats.valid || stats.ready;
  assign entry.ready = (state == ST_IDLE);

  assign re_sq = re_r * re_r;
  assign im_sq = im_r * im_r;
  assign lsq   = x * x;
  assign lsh   = lsq[63:31];
  assign lval  = $signed({2'b00, expo, frac}) - 23'sd1966080;
  assign prod  = lval * TEN_LOG10_2_Q16 + 42'sd8388608;

  assign trial = sq_res + sq_bit;
  assign sq_ge = sq_rem >= trial;
  assign res_n = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  assign q_db  = div_rsp.quotient[DB_W-1:0];

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'({1'b0, sabs}) + DIV_W'(total >> 1);
    div_req.divisor  = total;
    unique case (state)
      ST_IDLE: begin
        if (entry.valid) begin
          if (take) state_next = ST_SQ_RE;
          else if (entry.last_entry) state_next = ST_FIN_LO;
        end
      end
      ST_SQ_RE:  state_next = ST_SQ_IM;
      ST_SQ_IM:  state_next = ST_NORM;
      ST_NORM: begin
        if (x == '0) state_next = ST_SQUARE;
        else if (x[31]) state_next = ST_LOG;
      end
      ST_LOG:    if (iter == 4'd15) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_ACC;
      ST_ACC:    state_next = last_r ? ST_FIN_LO : ST_IDLE;
      ST_FIN_LO: state_next = (total == '0) ? ST_WRITE : ST_FIN_HI;
      ST_FIN_HI: state_next = ST_FIN_B;
      ST_FIN_B:  state_next = ST_FIN_A;
      ST_FIN_A:  state_next = ST_FIN_VAR;
      ST_FIN_VAR: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: if (div_rsp.done) state_next = ST_SQRT;
      ST_SQRT: begin
        if (sq_bit[0]) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(res_n[29:0]) + DIV_W'(total >> 1);
          state_next       = ST_DIV_STD;
        end
      end
      ST_DIV_STD: if (div_rsp.done) state_next = ST_WRITE;
      ST_WRITE:   if (slot_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath of one entry and of the final reduction.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        row_r  <= entry.row_index;
        col_r  <= entry.col_index;
        re_r   <= entry.real_part;
        im_r   <= entry.imag_part;
        last_r <= entry.last_entry;
      end
      ST_SQ_RE: m2 <= unsigned'(re_sq);
      ST_SQ_IM: begin
        x    <= m2 + unsigned'(im_sq);
        expo <= 5'd31;
      end
      ST_NORM: begin
        iter <= '0;
        frac <= '0;
        if (x == '0) v <= DB_FLOOR;
        else if (!x[31]) begin
          x    <= x << 1;
          expo <= expo - 1'b1;
        end
      end
      ST_LOG: begin
        // Each squaring of the mantissa yields one fraction bit of log2.
        frac <= {frac[14:0], lsh[32]};
        x    <= lsh[32] ? lsh[32:1] : lsh[31:0];
        iter <= iter + 1'b1;
      end
      ST_SCALE:  v <= prod[41:24];
      ST_SQUARE: vsq <= unsigned'(36'(v * v));
      ST_FIN_LO: begin
        mean_r  <= '0;
        std_r   <= '0;
        sum_neg <= run_sum[SUM_W-1];
        sabs    <= run_sum[SUM_W-1] ? 30'(-run_sum) : 30'(run_sum);
        plo     <= total * run_ssq[23:0];
      end
      ST_FIN_HI: phi <= total * run_ssq[47:24];
      ST_FIN_B:  bsq <= sabs * sabs;
      ST_FIN_A:  asq <= {phi, 24'd0} + 60'(plo);
      ST_FIN_VAR: var_r <= (asq > bsq) ? asq - bsq : '0;
      ST_DIV_MEAN: begin
        sq_res <= '0;
        sq_rem <= var_r;
        sq_bit <= 60'd1 << 58;
        if (div_rsp.done) mean_r <= sum_neg ? -$signed(q_db) : $signed(q_db);
      end
      ST_SQRT: begin
        if (sq_ge) sq_rem <= sq_rem - trial;
        sq_res <= res_n;
        sq_bit <= sq_bit >> 2;
      end
      ST_DIV_STD: begin
        if (div_rsp.done) begin
          std_r <= (div_rsp.quotient > DIV_W'(16'hFFFF)) ? 16'hFFFF
                                                         : div_rsp.quotient[STD_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Accumulators: updated per accumulated entry, cleared on reset and when the result is written.
  always_ff @(posedge clk) begin
    if (rst || (state == ST_WRITE && slot_free)) begin
      run_max  <= DB_FLOOR;
      run_min  <= DB_CEIL;
      amax_row <= '0;
      amax_col <= '0;
      run_sum  <= '0;
      run_ssq  <= '0;
      total    <= '0;
    end else if (state == ST_ACC) begin
      if (total == '0 || v > run_max) begin
        run_max  <= v;
        amax_row <= row_r;
        amax_col <= col_r;
      end
      if (total == '0 || v < run_min) run_min <= v;
      run_sum <= run_sum + SUM_W'(v);
      run_ssq <= run_ssq + SSQ_W'(vsq);
      total   <= total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats.valid <= 1'b0;
    end else if (state == ST_WRITE && slot_free) begin
      stats.valid <= 1'b1;
    end else if (stats.ready) begin
      stats.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && slot_free) begin
      stats.max_db     <= run_max;
      stats.max_row    <= amax_row;
      stats.max_col    <= amax_col;
      stats.min_db     <= run_min;
      stats.mean_db    <= mean_r;
      stats.std_db     <= std_r;
      stats.pair_count <= total;
    end
  end

  `ASSERT_CLK(a_count_cap, total <= COUNT_CAP, "entry count passed its cap")
  `ASSERT_CLK(a_write_shows, (state == ST_WRITE && slot_free) |=> stats.valid,
              "written result not shown")
  `ASSERT_CLK(a_empty_zero, (stats.valid && stats.pair_count == '0) |->
              (stats.mean_db == '0 && stats.std_db == '0), "empty set gave nonzero mean")

endmodule

[dv/db_magnitude_stream_statistics_core_tb.sv]
// Self-checking testbench for the dB magnitude statistics core.
`timescale 1ns / 100ps

module db_magnitude_stream_statistics_core_tb;
  import dbms_pkg::*;

  typedef struct {
    logic signed [DB_W-1:0] max_db;
    logic [ROW_W-1:0]       max_row;
    logic [ROW_W-1:0]       max_col;
    logic signed [DB_W-1:0] min_db;
    logic signed [DB_W-1:0] mean_db;
    logic [STD_W-1:0]       std_db;
    logic [CNT_W-1:0]       pair_count;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  dbms_entry_if entry ();
  dbms_stats_if stats ();

  db_magnitude_stream_statistics_core uut (
    .clk(clk), .rst(rst), .entry(entry.sink), .stats(stats.source)
  );

  always #2 clk = ~clk;

  // Predictor state.
  longint acc_max, acc_min, acc_sum;
  longint unsigned acc_sumsq;
  int unsigned acc_row, acc_col, acc_cnt;
  stats_t expected_stats[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  longint cycles = 0;
  bit stall_random = 1'b1;
  bit gaps_on = 1'b1;

  function automatic void clear_stats();
    acc_max = -102400; acc_min = 1024; acc_sum = 0; acc_sumsq = 0;
    acc_row = 0; acc_col = 0; acc_cnt = 0;
  endfunction

  function automatic longint entry_db_q8(logic signed [15:0] re, logic signed [15:0] im);
    longint m2, l, prod;
    longint unsigned x;
    int unsigned e, frac;
    m2 = longint'(re) * re + longint'(im) * im;
    if (m2 == 0) return -102400;
    e = 31;
    while (e > 0 && m2[e] == 1'b0) e--;
    x = longint'(m2) << (31 - e);
    frac = 0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        frac |= 1;
        x = x >> 1;
      end
    end
    l = longint'((e << 16) | frac) - (longint'(30) << 16);
    prod = l * 197283 + (longint'(1) << 23);
    // Arithmetic shift gives the floor division.
    return prod >>> 24;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void predict_entry(int unsigned r, int unsigned c,
                                        logic signed [15:0] re, logic signed [15:0] im,
                                        bit last);
    longint v, mean, cs;
    longint unsigned sabs, a, b, var_q, sd;
    stats_t s;
    if (r != c && r < MAX_PORTS_DEF && c < MAX_PORTS_DEF && acc_cnt < 4095) begin
      v = entry_db_q8(re, im);
      if (acc_cnt == 0 || v > acc_max) begin
        acc_max = v; acc_row = r; acc_col = c;
      end
      if (acc_cnt == 0 || v < acc_min) acc_min = v;
      acc_sum += v;
      acc_sumsq += longint'(v * v);
      acc_cnt++;
    end
    if (!last) return;
    mean = 0; sd = 0;
    if (acc_cnt > 0) begin
      cs = acc_cnt;
      if (acc_sum >= 0) mean = (acc_sum + cs / 2) / cs;
      else mean = -((-acc_sum + cs / 2) / cs);
      sabs = (acc_sum >= 0) ? acc_sum : -acc_sum;
      a = longint'(acc_cnt) * acc_sumsq;
      b = sabs * sabs;
      var_q = (a > b) ? a - b : 0;
      sd = (floor_sqrt(var_q) + acc_cnt / 2) / acc_cnt;
      if (sd > 65535) sd = 65535;
    end
    s.max_db = acc_max; s.max_row = acc_row; s.max_col = acc_col;
    s.min_db = acc_min; s.mean_db = mean; s.std_db = sd; s.pair_count = acc_cnt;
    expected_stats = {expected_stats, s};
    clear_stats();
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("Mismatch on result %0d, %s: got %0d, expected %0d",
             results_seen, field, got, want);
    errors++;
  endtask

  // Sender: one entry per transfer, with bursts and gaps.
  int burst_left = 0;
  task automatic send_entry(int unsigned r, int unsigned c, logic signed [15:0] re,
                            logic signed [15:0] im, bit last);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          entry.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    entry.valid <= 1'b1;
    entry.row_index <= r; entry.col_index <= c;
    entry.real_part <= re; entry.imag_part <= im; entry.last_entry <= last;
    do @(posedge clk); while (!entry.ready);
    predict_entry(r, c, re, im, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver stall pattern: alternates phases of random stalls and none.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (!stall_random || stall_phase < 100) stats.ready <= 1'b1;
    else if (stall_phase < 200) stats.ready <= ($urandom_range(0, 3) != 0);
    else stats.ready <= ($urandom_range(0, 9) < 3);
  end

  always @(posedge clk) begin
    stats_t e;
    if (!rst && stats.valid && stats.ready) begin
      if (expected_stats.size() == 0) begin
        $display("Unexpected result transfer %0d", results_seen);
        errors++;
      end else begin
        e = expected_stats.pop_front();
        if (stats.max_db !== e.max_db) report_mismatch("max_db", stats.max_db, e.max_db);
        if (stats.max_row !== e.max_row) report_mismatch("max_row", stats.max_row, e.max_row);
        if (stats.max_col !== e.max_col) report_mismatch("max_col", stats.max_col, e.max_col);
        if (stats.min_db !== e.min_db) report_mismatch("min_db", stats.min_db, e.min_db);
        if (stats.mean_db !== e.mean_db)
          report_mismatch("mean_db", stats.mean_db, e.mean_db);
        if (stats.std_db !== e.std_db) report_mismatch("std_db", stats.std_db, e.std_db);
        if (stats.pair_count !== e.pair_count)
          report_mismatch("pair_count", stats.pair_count, e.pair_count);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3_000_000) begin
      $display("Timeout with %0d results outstanding", expected_stats.size());
      $display("** db_magnitude_stream_statistics_core: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh0000;
      1: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      2: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_entry(0, 0, 16'sh7FFF, 0, 1'b1);            // diagonal only: empty set
    send_entry(0, 1, 0, 0, 1'b1);                    // zero magnitude
    send_entry(1, 0, 16'sh8000, 16'sh8000, 1'b0);    // largest magnitude
    send_entry(2, 3, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_entry(3, 2, 16'sh8000, 16'sh8000, 1'b0);    // equal maximum, first position kept
    send_entry(5, 5, 16'sh0001, 0, 1'b0);
    send_entry(63, 62, 16'sh0001, 0, 1'b0);          // smallest nonzero
    send_entry(62, 63, 0, 16'shFFFF, 1'b0);
    send_entry(7, 9, 16'sh1234, 16'shEDCC, 1'b1);
    send_entry(63, 63, 16'sh5555, 16'shAAAA, 1'b1);
    send_entry(10, 20, 16'sh2AAA, 16'sh5555, 1'b0);
    send_entry(21, 42, 16'shD555, 16'shAAAA, 1'b1);  // last entry accumulated
    send_entry(4, 8, -16'sd100, 16'sd100, 1'b1);     // single entry: zero spread
  endtask

  task automatic test_random_matrices();
    int unsigned n, r, c;
    while (items_sent < 340) begin
      n = $urandom_range(1, 4);  // small port counts keep sets short
      for (int i = 0; i < n * n; i++) begin
        r = i / n; c = i % n;
        if ($urandom_range(0, 9) == 0) begin
          r = $urandom_range(0, 63); c = $urandom_range(0, 63);
        end
        send_entry(r, c, rand_sample(), rand_sample(), i == n * n - 1);
      end
      if ($urandom_range(0, 7) == 0) send_entry($urandom_range(0, 63),
          $urandom_range(0, 63), rand_sample(), rand_sample(), 1'b1);
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    stall_random = 1'b0;
    for (int i = 0; i < 40; i++)
      send_entry($urandom_range(0, 63), $urandom_range(0, 63), rand_sample(),
                 rand_sample(), $urandom_range(0, 3) == 0);
    send_entry(1, 2, 16'sh0100, 0, 1'b1);
    gaps_on = 1'b1;
    stall_random = 1'b1;
  endtask

  initial begin
    entry.valid = 1'b0;
    entry.row_index = '0; entry.col_index = '0;
    entry.real_part = '0; entry.imag_part = '0; entry.last_entry = 1'b0;
    stats.ready = 1'b0;
    clear_stats();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_matrices();
    test_back_to_back();
    entry.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d entries covering empty, single-entry and random matrix sets,",
             items_sent);
    $display("checked %0d statistics results under random gaps and stalls.", results_seen);
    if (errors == 0) begin
      $display("** db_magnitude_stream_statistics_core: PASSED **");
    end else begin
      $display("** db_magnitude_stream_statistics_core: FAILED **");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+design
design/dbms_pkg.sv
design/dbms_entry_if.sv
design/dbms_stats_if.sv
design/dbms_div.sv
design/db_magnitude_stream_statistics_core.sv
dv/db_magnitude_stream_statistics_core_tb.sv
